// ===== sv/npg_pkg.sv =====
package npg_pkg;

	// defaults for the top level parameters
	localparam int LENGTH_DEF    = 9;
	localparam int ELEM_BITS_DEF = 8;

	// fixed field widths of the transactions
	localparam int OPCODE_W   = 1;
	localparam int POSITION_W = 4;
	localparam int VALUE_W    = 8;
	localparam int SLOT_W     = 4;
	localparam int ELEMENT_W  = 8;

	// opcodes of an input transaction
	localparam logic [OPCODE_W-1:0] OP_LOAD    = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_ADVANCE = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_wr;         // store the input value at its position
		logic scan_init;       // start the pivot scan at the last pair
		logic scan_rd;         // read the pair at the scan index
		logic scan_dec;        // step the scan one pair to the left
		logic pivot_cap;       // keep the pivot index and value
		logic srch_init;       // start the successor search at the last element
		logic srch_rd;         // read the element at the search index
		logic srch_dec;        // step the search one element to the left
		logic swap_q;          // write the pivot value at the successor index
		logic swap_p;          // write the successor value at the pivot index
		logic rev_init_full;   // reverse the whole sequence
		logic rev_init_suffix; // reverse the suffix after the pivot
		logic rev_rd;          // read both ends of the range
		logic rev_wr_lo;       // write the upper value at the lower end
		logic rev_wr_hi;       // write the lower value at the upper end and close in
		logic emit_init;       // start emitting at the first slot
		logic emit_rd;         // read the element at the emit index
		logic emit_inc;        // move to the next slot
		logic adv_set;         // assume a next arrangement exists
		logic adv_clr;         // no next arrangement, sequence wraps
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic scan_lt;   // left element of the pair below the right one
		logic idx_zero;  // scan reached the first pair
		logic srch_lt;   // pivot below the element read
		logic rev_done;  // range to reverse holds at most one element
		logic emit_last; // emit index at the last slot
	} status_t;

endpackage

// ===== sv/npg_if.sv =====
interface npg_in_if;

	logic                             valid;
	logic                             ready;
	logic [npg_pkg::OPCODE_W-1:0]     opcode;
	logic [npg_pkg::POSITION_W-1:0]   position;
	logic [npg_pkg::VALUE_W-1:0]      value;

	modport source (output valid, output opcode, output position, output value, input ready);
	modport sink   (input valid, input opcode, input position, input value, output ready);

endinterface

interface npg_out_if;

	logic                            valid;
	logic                            ready;
	logic [npg_pkg::SLOT_W-1:0]      slot;
	logic [npg_pkg::ELEMENT_W-1:0]   element;
	logic                            advanced;
	logic                            final_res;

	modport source (output valid, output slot, output element, output advanced,
		output final_res, input ready);
	modport sink   (input valid, input slot, input element, input advanced,
		input final_res, output ready);

endinterface

// ===== sv/next_permutation_generator_unit.sv =====
// load transaction: written to the store when taken, no result, input stays ready
// advance transaction: one memory step at a time through the sequence store
//   (one write port, two registered read ports)
// results leave one at a time, each held until taken; the next transaction is taken after the last
// reset clears the controller and the advanced flag; the sequence store holds no reset
module next_permutation_generator_unit #(
	parameter int LENGTH    = npg_pkg::LENGTH_DEF,
	parameter int ELEM_BITS = npg_pkg::ELEM_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	npg_in_if.sink       items,
	npg_out_if.source    results
);

	npg_pkg::cmd_t    cmd;
	npg_pkg::status_t status;

	// sequencing of scan, search, swap, reverse and emit
	npg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_opcode (items.opcode),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// sequence store, indices and compares
	npg_datapath #(
		.LENGTH    (LENGTH),
		.ELEM_BITS (ELEM_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.position  (items.position),
		.value     (items.value),
		.slot      (results.slot),
		.element   (results.element),
		.advanced  (results.advanced),
		.final_res (results.final_res)
	);

endmodule

// ===== sv/npg_datapath.sv =====
module npg_datapath #(
	parameter int LENGTH    = npg_pkg::LENGTH_DEF,
	parameter int ELEM_BITS = npg_pkg::ELEM_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  npg_pkg::cmd_t                      cmd,
	output npg_pkg::status_t                   status,
	input  logic [npg_pkg::POSITION_W-1:0]     position,
	input  logic [npg_pkg::VALUE_W-1:0]        value,
	output logic [npg_pkg::SLOT_W-1:0]         slot,
	output logic [npg_pkg::ELEMENT_W-1:0]      element,
	output logic                               advanced,
	output logic                               final_res
);

	localparam int IDX_W = $clog2(LENGTH);
	localparam int CNT_W = $clog2(LENGTH + 1);
	localparam logic [CNT_W-1:0] LAST_IDX   = CNT_W'(LENGTH - 1);
	localparam logic [CNT_W-1:0] SCAN_START = CNT_W'(LENGTH - 2);
	localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);
	localparam logic [npg_pkg::POSITION_W:0] LEN_POS = (npg_pkg::POSITION_W + 1)'(LENGTH);

	// sequence storage, no reset
	logic [ELEM_BITS-1:0] mem_q [LENGTH];

	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     lo_q;
	logic [CNT_W-1:0]     hi_q;
	logic [CNT_W-1:0]     p_q;
	logic [ELEM_BITS-1:0] pivot_q;
	logic [ELEM_BITS-1:0] rda_q;
	logic [ELEM_BITS-1:0] rdb_q;
	logic                 adv_q;

	logic [CNT_W-1:0]     raddr_a;
	logic [CNT_W-1:0]     raddr_b;
	logic                 re_a;
	logic                 re_b;
	logic                 we;
	logic [CNT_W-1:0]     waddr;
	logic [ELEM_BITS-1:0] wdata;
	logic                 pos_ok;

	logic [ELEM_BITS+npg_pkg::VALUE_W-1:0]   val_ext;
	logic [ELEM_BITS+npg_pkg::ELEMENT_W-1:0] elem_ext;
	logic [CNT_W+npg_pkg::SLOT_W-1:0]        slot_ext;
	logic [CNT_W:0]                          pos_ext;

	// load value and position fitted to the storage
	assign val_ext = {{ELEM_BITS{1'b0}}, value};
	assign pos_ext = (CNT_W + 1)'({1'b0, position});
	assign pos_ok  = {1'b0, position} < LEN_POS;

	// read port addresses
	assign raddr_a = cmd.rev_rd ? lo_q : idx_q;
	assign raddr_b = cmd.rev_rd ? hi_q : idx_q + ONE;
	assign re_a    = cmd.scan_rd | cmd.srch_rd | cmd.rev_rd | cmd.emit_rd;
	assign re_b    = cmd.scan_rd | cmd.rev_rd;

	// single write port
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = pivot_q;
		if (cmd.load_wr) begin
			we    = pos_ok;
			waddr = pos_ext[CNT_W-1:0];
			wdata = val_ext[ELEM_BITS-1:0];
		end else if (cmd.swap_q) begin
			we    = 1'b1;
			waddr = idx_q;
			wdata = pivot_q;
		end else if (cmd.swap_p) begin
			we    = 1'b1;
			waddr = p_q;
			wdata = rda_q;
		end else if (cmd.rev_wr_lo) begin
			we    = 1'b1;
			waddr = lo_q;
			wdata = rdb_q;
		end else if (cmd.rev_wr_hi) begin
			we    = 1'b1;
			waddr = hi_q;
			wdata = rda_q;
		end
	end

	// memory write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr[IDX_W-1:0]] <= wdata;
		end
		if (re_a) begin
			rda_q <= mem_q[raddr_a[IDX_W-1:0]];
		end
		if (re_b) begin
			rdb_q <= mem_q[raddr_b[IDX_W-1:0]];
		end
	end

	// pivot capture
	always_ff @(posedge clk) begin
		if (cmd.pivot_cap) begin
			p_q     <= idx_q;
			pivot_q <= rda_q;
		end
	end

	// index counters and advanced flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			lo_q  <= '0;
			hi_q  <= '0;
			adv_q <= 1'b0;
		end else begin
			if (cmd.scan_init) begin
				idx_q <= SCAN_START;
			end else if (cmd.srch_init) begin
				idx_q <= LAST_IDX;
			end else if (cmd.emit_init) begin
				idx_q <= '0;
			end else if (cmd.scan_dec || cmd.srch_dec) begin
				idx_q <= idx_q - ONE;
			end else if (cmd.emit_inc) begin
				idx_q <= idx_q + ONE;
			end
			if (cmd.rev_init_full) begin
				lo_q <= '0;
				hi_q <= LAST_IDX;
			end else if (cmd.rev_init_suffix) begin
				lo_q <= p_q + ONE;
				hi_q <= LAST_IDX;
			end else if (cmd.rev_wr_hi) begin
				lo_q <= lo_q + ONE;
				hi_q <= hi_q - ONE;
			end
			if (cmd.adv_set) begin
				adv_q <= 1'b1;
			end else if (cmd.adv_clr) begin
				adv_q <= 1'b0;
			end
		end
	end

	// status to the controller
	assign status.scan_lt   = rda_q < rdb_q;
	assign status.idx_zero  = idx_q == '0;
	assign status.srch_lt   = pivot_q < rda_q;
	assign status.rev_done  = !(lo_q < hi_q);
	assign status.emit_last = idx_q == LAST_IDX;

	// result payload
	assign elem_ext  = {{npg_pkg::ELEMENT_W{1'b0}}, rda_q};
	assign slot_ext  = {{npg_pkg::SLOT_W{1'b0}}, idx_q};
	assign element   = elem_ext[npg_pkg::ELEMENT_W-1:0];
	assign slot      = slot_ext[npg_pkg::SLOT_W-1:0];
	assign advanced  = adv_q;
	assign final_res = idx_q == LAST_IDX;

endmodule

// ===== sv/npg_ctrl.sv =====
module npg_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [npg_pkg::OPCODE_W-1:0]    in_opcode,
	output logic                            in_ready,
	output logic                            out_valid,
	input  logic                            out_ready,
	output npg_pkg::cmd_t                   cmd,
	input  npg_pkg::status_t                status
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SWAP_P,
		ST_REV_RD,
		ST_REV_WR_LO,
		ST_REV_WR_HI,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_acc;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = state_q == ST_EMIT_OUT;
	assign in_acc    = in_valid && in_ready;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_opcode == npg_pkg::OP_ADVANCE) begin
						cmd.scan_init = 1'b1;
						cmd.adv_set   = 1'b1;
						state_d       = ST_SCAN_RD;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			ST_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				if (status.scan_lt) begin
					cmd.pivot_cap = 1'b1;
					cmd.srch_init = 1'b1;
					state_d       = ST_SRCH_RD;
				end else if (status.idx_zero) begin
					cmd.adv_clr       = 1'b1;
					cmd.rev_init_full = 1'b1;
					state_d           = ST_REV_RD;
				end else begin
					cmd.scan_dec = 1'b1;
					state_d      = ST_SCAN_RD;
				end
			end
			ST_SRCH_RD: begin
				cmd.srch_rd = 1'b1;
				state_d     = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				if (status.srch_lt) begin
					cmd.swap_q = 1'b1;
					state_d    = ST_SWAP_P;
				end else begin
					cmd.srch_dec = 1'b1;
					state_d      = ST_SRCH_RD;
				end
			end
			ST_SWAP_P: begin
				cmd.swap_p          = 1'b1;
				cmd.rev_init_suffix = 1'b1;
				state_d             = ST_REV_RD;
			end
			ST_REV_RD: begin
				if (status.rev_done) begin
					cmd.emit_init = 1'b1;
					state_d       = ST_EMIT_RD;
				end else begin
					cmd.rev_rd = 1'b1;
					state_d    = ST_REV_WR_LO;
				end
			end
			ST_REV_WR_LO: begin
				cmd.rev_wr_lo = 1'b1;
				state_d       = ST_REV_WR_HI;
			end
			ST_REV_WR_HI: begin
				cmd.rev_wr_hi = 1'b1;
				state_d       = ST_REV_RD;
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (out_ready) begin
					if (status.emit_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.emit_inc = 1'b1;
						state_d      = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/npg_checker.sv =====
module npg_checker #(
	parameter int LENGTH = npg_pkg::LENGTH_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [npg_pkg::OPCODE_W-1:0]     in_opcode,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [npg_pkg::SLOT_W-1:0]       out_slot,
	input logic [npg_pkg::ELEMENT_W-1:0]    out_element,
	input logic                             out_advanced,
	input logic                             out_final
);

	localparam logic [npg_pkg::SLOT_W-1:0] LAST_SLOT = npg_pkg::SLOT_W'(LENGTH - 1);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_element)
			&& $stable(out_advanced) && $stable(out_final))
		else $error("stalled result changed");

	// no new transaction taken while results are pending
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result is pending");

	// the final marker sits on the last slot only
	a_final_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_final == (out_slot == LAST_SLOT)))
		else $error("final marker on the wrong slot");

	// a load gives no result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_opcode == npg_pkg::OP_LOAD |=> !out_valid && in_ready)
		else $error("load transaction produced a result");

endmodule

bind next_permutation_generator_unit npg_checker #(
	.LENGTH (LENGTH)
) u_npg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (items.valid),
	.in_ready     (items.ready),
	.in_opcode    (items.opcode),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.out_slot     (results.slot),
	.out_element  (results.element),
	.out_advanced (results.advanced),
	.out_final    (results.final_res)
);
